### rtl/core/tetrahedron_circumcenter_offset_defines.svh
// ----------------------------------------------------------------------------
// Tetrahedron circumcenter offset: assertion macros
// Shared property forms for the checker of the circumcenter offset block.
// ----------------------------------------------------------------------------
`ifndef TETRAHEDRON_CIRCUMCENTER_OFFSET_DEFINES_SVH
`define TETRAHEDRON_CIRCUMCENTER_OFFSET_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TCO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold at every clock edge outside reset.
`define TCO_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### rtl/core/tco_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcenter offset package
// Widths, types and multiply helpers shared by the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tco_pkg;

  // Coordinate width; all internal widths follow from it.
  localparam int COORD_W = 32;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CRS_W   = PROD_W + 1;
  localparam int SPL_W   = (CRS_W + 1) / 2;
  localparam int HI_W    = CRS_W - SPL_W;
  localparam int PP_W    = 2 * (SPL_W + 1);
  localparam int DET_W   = EDGE_W + CRS_W + 2;
  localparam int NUM_W   = CRS_W + CRS_W + 2;
  localparam int DEN_W   = DET_W + 1;
  localparam int Q_W     = COORD_W + 1;
  localparam int CMP_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  // Stage counts of each part and of the whole block.
  localparam int GEOM_LAT = 4;
  localparam int PROD_LAT = 3;
  localparam int DIV_LAT  = Q_W + 3;
  localparam int PIPE_LAT = GEOM_LAT + PROD_LAT + DIV_LAT + 1;

  // Saturation limits of the quotient magnitude.
  localparam logic [Q_W:0] LIM_POS = (Q_W+1)'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [Q_W:0] LIM_NEG = (Q_W+1)'(64'd1 << (COORD_W - 1));

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CRS_W-1:0]   crs_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  localparam coord_t COORD_MAX = coord_t'(LIM_POS);
  localparam coord_t COORD_MIN = coord_t'(LIM_NEG);

  // Four partial products of one split multiplication.
  typedef struct packed {
    logic signed [PP_W-1:0] hh;
    logic signed [PP_W-1:0] lh;
    logic signed [PP_W-1:0] hl;
    logic signed [PP_W-1:0] ll;
  } pp4_t;

  // Splits both operands into an unsigned low half and a signed high half.
  function automatic pp4_t split_mul(crs_t x, crs_t y);
    logic        [SPL_W-1:0] xl;
    logic        [SPL_W-1:0] yl;
    logic signed [HI_W-1:0]  xh;
    logic signed [HI_W-1:0]  yh;
    pp4_t r;
    xl = x[SPL_W-1:0];
    yl = y[SPL_W-1:0];
    xh = x[CRS_W-1:SPL_W];
    yh = y[CRS_W-1:SPL_W];
    r.ll = PP_W'($signed({1'b0, xl})) * PP_W'($signed({1'b0, yl}));
    r.lh = PP_W'($signed({1'b0, xl})) * PP_W'(yh);
    r.hl = PP_W'(xh) * PP_W'($signed({1'b0, yl}));
    r.hh = PP_W'(xh) * PP_W'(yh);
    return r;
  endfunction

  // Recombines the partial products into the full signed product.
  function automatic num_t pp_sum(pp4_t p);
    return (NUM_W'(p.hh) <<< (2 * SPL_W)) +
           ((NUM_W'(p.lh) + NUM_W'(p.hl)) <<< SPL_W) + NUM_W'(p.ll);
  endfunction

endpackage

### rtl/core/tco_geom.sv
// ----------------------------------------------------------------------------
// Tetrahedron geometry stages
// Captures the vertices, forms edge vectors, squared lengths and cross products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tco_geom import tco_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_vld,
  input  coord_t vtx [4][3],
  output logic   out_vld,
  output crs_t   len [3],
  output crs_t   crs [3][3],
  output edge_t  e0 [3]
);

  logic   v0_r, v1_r, v2_r, v3_r;
  coord_t vtx_r [4][3];
  edge_t  edg_r [3][3];
  prod_t  sq_r [3][3];
  prod_t  cp_r [3][3][2];
  edge_t  e0a_r [3];
  crs_t   len_r [3];
  crs_t   crs_r [3][3];
  edge_t  e0b_r [3];

  // Valid bits travel with the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload stages. Cross k uses edges k+1 and k+2, giving cd, db and bc.
  always_ff @(posedge clk) begin
    vtx_r <= vtx;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        edg_r[k][i] <= EDGE_W'(vtx_r[k+1][i]) - EDGE_W'(vtx_r[0][i]);
        sq_r[k][i]  <= PROD_W'(edg_r[k][i]) * PROD_W'(edg_r[k][i]);
        cp_r[k][i][0] <= PROD_W'(edg_r[(k+1)%3][(i+1)%3]) *
                         PROD_W'(edg_r[(k+2)%3][(i+2)%3]);
        cp_r[k][i][1] <= PROD_W'(edg_r[(k+2)%3][(i+1)%3]) *
                         PROD_W'(edg_r[(k+1)%3][(i+2)%3]);
        crs_r[k][i] <= CRS_W'(cp_r[k][i][0]) - CRS_W'(cp_r[k][i][1]);
      end
      len_r[k] <= CRS_W'(sq_r[k][0]) + CRS_W'(sq_r[k][1]) + CRS_W'(sq_r[k][2]);
    end
    e0a_r <= edg_r[0];
    e0b_r <= e0a_r;
  end

  assign out_vld = v3_r;
  assign len     = len_r;
  assign crs     = crs_r;
  assign e0      = e0b_r;

endmodule

### rtl/core/tco_prod.sv
// ----------------------------------------------------------------------------
// Tetrahedron numerator and determinant stages
// Weighted cross-product sums and the volume determinant, via split multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tco_prod import tco_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  crs_t  len [3],
  input  crs_t  crs [3][3],
  input  edge_t e0 [3],
  output logic  out_vld,
  output num_t  num [3],
  output det_t  det
);

  logic v0_r, v1_r, v2_r;
  pp4_t pn_r [3][3];
  pp4_t pd_r [3];
  num_t tn_r [3][3];
  num_t td_r [3];
  num_t num_r [3];
  det_t det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Partial products, then full products, then the three-term sums.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pn_r[k][i] <= split_mul(len[k], crs[k][i]);
        tn_r[k][i] <= pp_sum(pn_r[k][i]);
      end
      pd_r[i]  <= split_mul(CRS_W'(e0[i]), crs[0][i]);
      td_r[i]  <= pp_sum(pd_r[i]);
      num_r[i] <= tn_r[0][i] + tn_r[1][i] + tn_r[2][i];
    end
    det_r <= DET_W'(td_r[0] + td_r[1] + td_r[2]);
  end

  assign out_vld = v2_r;
  assign num     = num_r;
  assign det     = det_r;

endmodule

### rtl/core/tco_div.sv
// ----------------------------------------------------------------------------
// Tetrahedron offset divider lane
// Pipelined restoring division of one numerator by twice the determinant,
// with round-half-away rounding and saturation to the coordinate range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tco_div import tco_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_vld,
  input  num_t   num,
  input  det_t   det,
  output logic   out_vld,
  output coord_t res,
  output logic   sat,
  output logic   dz
);

  det_t             dabs;
  logic             pv_r;
  logic             pneg_r;
  logic             pdz_r;
  logic [CMP_W-1:0] pnum_r;
  logic [DEN_W-1:0] pden_r;

  logic             vld_r [Q_W+1];
  logic             neg_r [Q_W+1];
  logic             dzs_r [Q_W+1];
  logic             ovf_r [Q_W+1];
  logic [CMP_W-1:0] rem_r [Q_W+1];
  logic [DEN_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   quo_r [Q_W+1];

  logic             fv_r;
  coord_t           res_r;
  logic             sat_r;
  logic             dz_r;

  logic             up;
  logic [Q_W:0]     qr;
  logic [Q_W:0]     lim;
  logic             sat_nxt;
  logic [Q_W:0]     mag;

  assign dabs = det[DET_W-1] ? -det : det;

  // Magnitudes and sign of the quotient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pneg_r <= num[NUM_W-1] ^ det[DET_W-1];
    pdz_r  <= (det == '0);
    pnum_r <= CMP_W'(unsigned'(num[NUM_W-1] ? -num : num));
    pden_r <= DEN_W'(unsigned'(dabs)) << 1;
  end

  // Quotients past the bit range saturate without dividing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r[0] <= pnum_r >= (CMP_W'(pden_r) << Q_W);
    neg_r[0] <= pneg_r;
    dzs_r[0] <= pdz_r;
    rem_r[0] <= pnum_r;
    den_r[0] <= pden_r;
    quo_r[0] <= '0;
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int J = Q_W - 1 - s;
    logic [CMP_W-1:0] dsh;
    logic             ge;

    assign dsh = CMP_W'(den_r[s]) << J;
    assign ge  = rem_r[s] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? rem_r[s] - dsh : rem_r[s];
      quo_r[s+1] <= {quo_r[s][Q_W-2:0], ge};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      dzs_r[s+1] <= dzs_r[s];
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  // Round half away from zero, then clip to the signed range.
  always_comb begin
    up      = (rem_r[Q_W] << 1) >= CMP_W'(den_r[Q_W]);
    qr      = {1'b0, quo_r[Q_W]} + (Q_W+1)'(up);
    lim     = neg_r[Q_W] ? LIM_NEG : LIM_POS;
    sat_nxt = ovf_r[Q_W] | (qr > lim);
    mag     = sat_nxt ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= vld_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= coord_t'(neg_r[Q_W] ? -mag : mag);
    sat_r <= sat_nxt;
    dz_r  <= dzs_r[Q_W];
  end

  assign out_vld = fv_r;
  assign res     = res_r;
  assign sat     = sat_r;
  assign dz      = dz_r;

endmodule

### rtl/core/tetrahedron_circumcenter_offset.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcenter offset
// Offset of a tetrahedron's circumcenter from its first vertex, Q15.16.
// ----------------------------------------------------------------------------
// A beat is taken on every clock edge where start is high; busy is never
// raised, so one tetrahedron can enter per cycle. Each result appears on the
// out_ ports for exactly one cycle with out_valid high. The pipeline holds the
// 33-stage restoring divider (one quotient bit per stage) plus eleven stages
// of edge, product and rounding logic. The receiver cannot stall, so results
// must be taken as they come. A zero determinant gives zero offsets with
// out_degenerate set.
`timescale 1ns / 1ps

module tetrahedron_circumcenter_offset import tco_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  coord_t in_a_x,
  input  coord_t in_a_y,
  input  coord_t in_a_z,
  input  coord_t in_b_x,
  input  coord_t in_b_y,
  input  coord_t in_b_z,
  input  coord_t in_c_x,
  input  coord_t in_c_y,
  input  coord_t in_c_z,
  input  coord_t in_d_x,
  input  coord_t in_d_y,
  input  coord_t in_d_z,
  output logic   out_valid,
  output coord_t out_offset_x,
  output coord_t out_offset_y,
  output coord_t out_offset_z,
  output logic   out_degenerate,
  output logic   out_saturated
);

  coord_t vtx [4][3];
  logic   g_vld;
  crs_t   len [3];
  crs_t   crs [3][3];
  edge_t  e0 [3];
  logic   p_vld;
  num_t   num [3];
  det_t   det;
  logic   d_vld [3];
  coord_t res [3];
  logic   sat [3];
  logic   dz [3];

  logic   out_valid_r;
  coord_t off_r [3];
  logic   degen_r;
  logic   sat_r;

  // The pipeline never stalls.
  assign busy = 1'b0;

  assign vtx[0] = '{in_a_x, in_a_y, in_a_z};
  assign vtx[1] = '{in_b_x, in_b_y, in_b_z};
  assign vtx[2] = '{in_c_x, in_c_y, in_c_z};
  assign vtx[3] = '{in_d_x, in_d_y, in_d_z};

  tco_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .vtx     (vtx),
    .out_vld (g_vld),
    .len     (len),
    .crs     (crs),
    .e0      (e0)
  );

  tco_prod u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g_vld),
    .len     (len),
    .crs     (crs),
    .e0      (e0),
    .out_vld (p_vld),
    .num     (num),
    .det     (det)
  );

  // One divider lane per axis.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    tco_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (p_vld),
      .num     (num[i]),
      .det     (det),
      .out_vld (d_vld[i]),
      .res     (res[i]),
      .sat     (sat[i]),
      .dz      (dz[i])
    );
  end

  // Output register; a degenerate beat forces zero offsets and no saturation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      off_r[i] <= dz[0] ? '0 : res[i];
    end
    degen_r <= dz[0];
    sat_r   <= ~dz[0] & (sat[0] | sat[1] | sat[2]);
  end

  assign out_valid      = out_valid_r;
  assign out_offset_x   = off_r[0];
  assign out_offset_y   = off_r[1];
  assign out_offset_z   = off_r[2];
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;

endmodule

### rtl/core/tco_checker.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcenter offset checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tetrahedron_circumcenter_offset_defines.svh"

module tco_checker import tco_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   start,
  input logic   busy,
  input logic   out_valid,
  input coord_t out_offset_x,
  input coord_t out_offset_y,
  input coord_t out_offset_z,
  input logic   out_degenerate,
  input logic   out_saturated
);

  logic acc_beat;
  logic degen_beat;
  logic off_zero;
  logic sat_beat;
  logic off_bound;

  // Port conditions the assertions refer to.
  assign acc_beat   = start && !busy;
  assign degen_beat = out_valid && out_degenerate;
  assign off_zero   = (out_offset_x == '0) && (out_offset_y == '0) &&
                      (out_offset_z == '0);
  assign sat_beat   = out_valid && out_saturated;
  assign off_bound  = (out_offset_x == COORD_MAX) || (out_offset_x == COORD_MIN) ||
                      (out_offset_y == COORD_MAX) || (out_offset_y == COORD_MIN) ||
                      (out_offset_z == COORD_MAX) || (out_offset_z == COORD_MIN);

  // Every result beat traces back to an accepted beat a fixed time earlier.
  `TCO_ASSERT_IMP(a_latency, out_valid, $past(acc_beat, PIPE_LAT), "result without input beat")

  // A degenerate result carries zero offsets.
  `TCO_ASSERT_IMP(a_degen_zero, degen_beat, off_zero, "degenerate offsets not zero")

  // A degenerate result is never marked saturated.
  `TCO_ASSERT_ALWAYS(a_degen_sat, !(degen_beat && out_saturated), "degenerate and saturated")

  // A saturated result has at least one offset at a range bound.
  `TCO_ASSERT_IMP(a_sat_bound, sat_beat, off_bound, "saturated without bound")

endmodule

bind tetrahedron_circumcenter_offset tco_checker u_tco_checker (.*);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Tetrahedron circumcenter offset testbench
// Drives directed vertex beats, then random bursts; predicts each offset with
// exact wide integer arithmetic and checks every result beat against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import tco_pkg::*; ();

  typedef logic signed [255:0] wide_t;

  // One expected result beat.
  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    logic   degen;
    logic   sat;
  } offset_t;

  // Exact rounded, saturated quotient of num by a positive den.
  function automatic coord_t round_div(wide_t num, wide_t den, ref logic sat);
    logic  neg;
    wide_t mag;
    wide_t q;
    wide_t r;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    if (!neg && q > wide_t'(64'sd2147483647)) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (neg && q > wide_t'(64'sd2147483648)) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return neg ? coord_t'(-q) : coord_t'(q);
  endfunction

  // Circumcenter offset from vertex a for one tetrahedron.
  function automatic offset_t circumcenter(coord_t v[12]);
    wide_t   e[3][3];
    wide_t   len[3];
    wide_t   cd[3];
    wide_t   db[3];
    wide_t   bc[3];
    wide_t   det;
    wide_t   den;
    wide_t   num;
    coord_t  o[3];
    offset_t r;
    logic    sat;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        e[k][i] = wide_t'(v[3*(k+1)+i]) - wide_t'(v[i]);
    for (int k = 0; k < 3; k++)
      len[k] = e[k][0]*e[k][0] + e[k][1]*e[k][1] + e[k][2]*e[k][2];
    cd[0] = e[1][1]*e[2][2] - e[2][1]*e[1][2];
    cd[1] = e[1][2]*e[2][0] - e[2][2]*e[1][0];
    cd[2] = e[1][0]*e[2][1] - e[2][0]*e[1][1];
    db[0] = e[2][1]*e[0][2] - e[0][1]*e[2][2];
    db[1] = e[2][2]*e[0][0] - e[0][2]*e[2][0];
    db[2] = e[2][0]*e[0][1] - e[0][0]*e[2][1];
    bc[0] = e[0][1]*e[1][2] - e[1][1]*e[0][2];
    bc[1] = e[0][2]*e[1][0] - e[1][2]*e[0][0];
    bc[2] = e[0][0]*e[1][1] - e[1][0]*e[0][1];
    det = e[0][0]*cd[0] + e[0][1]*cd[1] + e[0][2]*cd[2];
    sat = 1'b0;
    if (det == 0) begin
      r = '{0, 0, 0, 1'b1, 1'b0};
      return r;
    end
    den = 2 * det;
    for (int i = 0; i < 3; i++) begin
      num = len[0]*cd[i] + len[1]*db[i] + len[2]*bc[i];
      if (den < 0) num = -num;
      o[i] = round_div(num, den < 0 ? -den : den, sat);
    end
    r = '{o[0], o[1], o[2], 1'b0, sat};
    return r;
  endfunction

  // Queue of predicted offsets, oldest first.
  class offset_scoreboard;
    offset_t pending[$];
    int      mismatches;
    int      checked;
    int      degen_seen;
    int      sat_seen;

    function void note_beat(coord_t v[12]);
      pending.push_back(circumcenter(v));
    endfunction

    function void check_result(offset_t got);
      offset_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t", $time);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.degen) degen_seen++;
      if (exp_r.sat) sat_seen++;
      if (got != exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch at %0t: exp %0d %0d %0d d%0b s%0b, got %0d %0d %0d d%0b s%0b",
                   $time, exp_r.ox, exp_r.oy, exp_r.oz, exp_r.degen, exp_r.sat,
                   got.ox, got.oy, got.oz, got.degen, got.sat);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t vin[12] = '{default: '0};
  logic   out_valid;
  coord_t out_offset_x;
  coord_t out_offset_y;
  coord_t out_offset_z;
  logic   out_degenerate;
  logic   out_saturated;

  offset_scoreboard sb = new();
  int beats_sent;

  always #6 clk = ~clk;

  tetrahedron_circumcenter_offset u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(vin[0]), .in_a_y(vin[1]), .in_a_z(vin[2]),
    .in_b_x(vin[3]), .in_b_y(vin[4]), .in_b_z(vin[5]),
    .in_c_x(vin[6]), .in_c_y(vin[7]), .in_c_z(vin[8]),
    .in_d_x(vin[9]), .in_d_y(vin[10]), .in_d_z(vin[11]),
    .out_valid(out_valid), .out_offset_x(out_offset_x), .out_offset_y(out_offset_y),
    .out_offset_z(out_offset_z), .out_degenerate(out_degenerate),
    .out_saturated(out_saturated)
  );

  // Result beats are taken at the edge that ends their cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_offset_x, out_offset_y, out_offset_z,
                        out_degenerate, out_saturated});
  end

  // Input beats are noted at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_beat(vin);
      beats_sent++;
    end
  end

  // Presents one beat and holds it until accepted; start stays high.
  task automatic send_beat(coord_t v[12]);
    foreach (vin[i]) vin[i] <= v[i];
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random coordinate: full range, or a small value near some center.
  function automatic coord_t rand_coord(int mode, coord_t base);
    case (mode)
      0: return coord_t'($urandom);
      1: return base + coord_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return base + coord_t'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
    endcase
  endfunction

  initial begin
    coord_t v[12];
    coord_t base;
    int     mode;
    int     burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit corner simplex, degenerate cases, extremes and saturation.
    v = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
    send_beat(v);
    v = '{0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0, 0, 0, 32'h10000};
    send_beat(v);
    foreach (v[i]) v[i] = 32'h12345;
    send_beat(v);
    foreach (v[i]) v[i] = COORD_MIN;
    send_beat(v);
    v = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
          COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX};
    send_beat(v);
    v = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
          COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN};
    send_beat(v);
    // Nearly flat: tiny volume forces saturation.
    v = '{0, 0, 0, 32'h7fff0000, 0, 0, 0, 32'h7fff0000, 0, 32'h40000000, 32'h40000000, 1};
    send_beat(v);
    v = '{0, 0, 0, 32'h7fff0000, 0, 0, 0, 32'h7fff0000, 0, 32'h40000000, 32'h40000000, -1};
    send_beat(v);
    v = '{-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0};
    send_beat(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_beat(v);
    v = '{0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 0, 1};
    send_beat(v);
    // Collinear points are degenerate.
    v = '{0, 0, 0, 32'h10000, 32'h10000, 0, 32'h20000, 32'h20000, 0, 7, 7, 32'h10000};
    send_beat(v);

    // Random part in bursts with gaps.
    while (beats_sent < 1130) begin
      burst = $urandom_range(1, 40);
      for (int n = 0; n < burst; n++) begin
        mode = $urandom_range(0, 5);
        base = coord_t'($urandom);
        foreach (v[i]) v[i] = rand_coord(mode % 3, base);
        if (mode == 5) begin
          // Coplanar set: all z equal.
          v[5] = v[2]; v[8] = v[2]; v[11] = v[2];
        end
        send_beat(v);
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 60));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("Sent %0d tetrahedra, checked %0d results (%0d degenerate, %0d saturated).",
             beats_sent, sb.checked, sb.degen_seen, sb.sat_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
